### rtl/bdlp_pkg.sv
// shared types, codes and constants for the button debounce and long-press encoder
package bdlp_pkg;

   // button count and roles
   localparam int unsigned NUM_BTN   = 3;
   localparam int unsigned ENTER_BTN = 1;
   localparam int unsigned UP_BTN    = 0;
   localparam int unsigned DOWN_BTN  = 2;

   // counter and register widths
   localparam int unsigned CNT_W   = 16;
   localparam int unsigned PHASE_W = 3;

   // repeat step comes once every REPEAT_MOD polls while long-pressed
   localparam int unsigned REPEAT_MOD = 5;

   // key state codes
   typedef logic [1:0] key_state_type;
   localparam key_state_type KS_RELEASED = 2'd0;
   localparam key_state_type KS_SHORT    = 2'd1;
   localparam key_state_type KS_LONG     = 2'd2;

   // encoder step codes, two bit signed
   typedef logic signed [1:0] step_type;
   localparam step_type STEP_NONE  = 2'sb00;
   localparam step_type STEP_PLUS  = 2'sb01;
   localparam step_type STEP_MINUS = 2'sb11;

   // opcodes carried in tuser
   localparam logic OP_SCAN = 1'b0;
   localparam logic OP_POLL = 1'b1;

   // register indexes
   localparam logic REG_DEBOUNCE   = 1'b0;
   localparam logic REG_LONG_PRESS = 1'b1;

   // register reset values
   localparam logic [CNT_W-1:0] DEBOUNCE_RESET   = 16'd2;
   localparam logic [CNT_W-1:0] LONG_PRESS_RESET = 16'd100;

   // per-button scan control
   typedef struct packed {
      logic scan_en;
      logic level;
   } scan_ctl_type;

   // all key states, button i at index i
   typedef key_state_type [NUM_BTN-1:0] key_vec_type;

endpackage

### rtl/bdlp_btn.sv
// one button: level history, hold counter and debounced key state
module bdlp_btn (
   input  logic                       clock,
   input  logic                       reset,
   input  bdlp_pkg::scan_ctl_type     ctl,
   input  logic [bdlp_pkg::CNT_W-1:0] debounce_ticks,
   input  logic [bdlp_pkg::CNT_W-1:0] long_press_ticks,
   output bdlp_pkg::key_state_type    key_cur,
   output bdlp_pkg::key_state_type    key_nxt
);
   import bdlp_pkg::*;

   logic                prev_level_ff;
   logic                prev_level_in;
   logic [CNT_W-1:0]    hold_count_ff;
   logic [CNT_W-1:0]    hold_count_in;
   key_state_type       key_ff;
   key_state_type       key_in;
   logic [CNT_W:0]      cnt;

   // count the run of equal levels, saturate at the long-press limit
   always_comb begin
      prev_level_in = prev_level_ff;
      hold_count_in = hold_count_ff;
      key_in        = key_ff;
      if (ctl.level == prev_level_ff) begin
         cnt = {1'b0, hold_count_ff} + {{CNT_W{1'b0}}, 1'b1};
      end else begin
         cnt = '0;
      end
      if (ctl.scan_en) begin
         prev_level_in = ctl.level;
         if (cnt >= {1'b0, long_press_ticks}) begin
            hold_count_in = long_press_ticks;
            if (!ctl.level) begin
               key_in = KS_LONG;
            end
         end else begin
            hold_count_in = cnt[CNT_W-1:0];
            if (cnt > {1'b0, debounce_ticks}) begin
               key_in = ctl.level ? KS_RELEASED : KS_SHORT;
            end
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_level_ff <= 1'b1;
         hold_count_ff <= '0;
         key_ff        <= KS_RELEASED;
      end else begin
         prev_level_ff <= prev_level_in;
         hold_count_ff <= hold_count_in;
         key_ff        <= key_in;
      end
   end

   assign key_cur = key_ff;
   assign key_nxt = key_in;

endmodule

### rtl/bdlp_poll.sv
// poll logic: edge detect on short presses and auto-repeat while long-pressed
module bdlp_poll (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  poll_en,
   input  bdlp_pkg::key_vec_type key_states,
   output bdlp_pkg::step_type    step
);
   import bdlp_pkg::*;

   key_vec_type         polled_ff;
   key_vec_type         polled_in;
   logic [PHASE_W-1:0]  up_phase_ff;
   logic [PHASE_W-1:0]  up_phase_in;
   logic [PHASE_W-1:0]  down_phase_ff;
   logic [PHASE_W-1:0]  down_phase_in;
   step_type            step_sel;

   // phase advance modulo the repeat period
   function automatic logic [PHASE_W-1:0] next_phase(input logic [PHASE_W-1:0] ph);
      logic [PHASE_W-1:0] r;
      if (ph >= PHASE_W'(REPEAT_MOD - 1)) begin
         r = '0;
      end else begin
         r = ph + PHASE_W'(1);
      end
      return r;
   endfunction

   // up button first, down button only when up is neither new short nor long
   always_comb begin
      up_phase_in   = up_phase_ff;
      down_phase_in = down_phase_ff;
      polled_in     = polled_ff;
      step_sel      = STEP_NONE;
      if (key_states[UP_BTN] == KS_SHORT && polled_ff[UP_BTN] != KS_SHORT) begin
         step_sel = STEP_PLUS;
      end else if (key_states[UP_BTN] == KS_LONG) begin
         up_phase_in = next_phase(up_phase_ff);
         step_sel    = (up_phase_in == '0) ? STEP_PLUS : STEP_NONE;
      end else if (key_states[DOWN_BTN] == KS_SHORT &&
                   polled_ff[DOWN_BTN] != KS_SHORT) begin
         step_sel = STEP_MINUS;
      end else if (key_states[DOWN_BTN] == KS_LONG) begin
         down_phase_in = next_phase(down_phase_ff);
         step_sel      = (down_phase_in == '0) ? STEP_MINUS : STEP_NONE;
      end
      if (!poll_en) begin
         up_phase_in   = up_phase_ff;
         down_phase_in = down_phase_ff;
      end else begin
         polled_in = key_states;
      end
   end

   // poll history registers
   always_ff @(posedge clock) begin
      if (reset) begin
         polled_ff     <= {NUM_BTN{KS_RELEASED}};
         up_phase_ff   <= '0;
         down_phase_ff <= '0;
      end else begin
         polled_ff     <= polled_in;
         up_phase_ff   <= up_phase_in;
         down_phase_ff <= down_phase_in;
      end
   end

   assign step = poll_en ? step_sel : STEP_NONE;

endmodule

### rtl/button_debounce_long_press_encoder.sv
// top level of the three-button debouncer with long-press encoder interface
//
// Input stream req_*: one beat per item. req_tuser is the opcode (scan tick
// or poll), req_tdata[2:0] the raw active-low pin levels of the three
// buttons (used on a scan tick only). Every input beat gives exactly one
// result beat on rsp_*: rsp_tdata holds the key states of all buttons, the
// enter flag and the signed encoder step (zero on a scan tick).
// A beat is caught in the input register; the button and poll logic then
// update their state and load the result register once it is free.
// Throughput is one beat per cycle while the receiver does not stall; the
// button state update is a single counter increment, compare and select per
// button, done side by side for the three buttons.
// When the receiver stalls, the result register holds and the input
// register holds one more beat; req_tready then stays low until the result
// is taken. Reset (synchronous) empties both registers, sets the debounce
// limit to 2 and the long-press limit to 100, marks all buttons released
// with zero hold count, and clears the poll history and repeat phases.
// The csr_* port writes a limit register and should be used while no
// beat is in flight.
module button_debounce_long_press_encoder (
   input  logic                       clock,
   input  logic                       reset,
   // input stream
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [7:0]                 req_tdata,   // [2:0] pin_levels
   input  logic                       req_tuser,   // [0] opcode
   // result stream
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [15:0]                rsp_tdata,   // [5:0] key_states, [6] enter_pressed,
                                                   // [8:7] step
   // configuration
   input  logic                       csr_we,
   input  logic                       csr_index,
   input  logic [bdlp_pkg::CNT_W-1:0] csr_wdata
);
   import bdlp_pkg::*;

   logic [CNT_W-1:0]       debounce_ff;
   logic [CNT_W-1:0]       debounce_in;
   logic [CNT_W-1:0]       long_press_ff;
   logic [CNT_W-1:0]       long_press_in;
   logic                   in_vld_ff;
   logic                   in_vld_in;
   logic                   in_op_ff;
   logic [NUM_BTN-1:0]     in_pins_ff;
   logic                   out_vld_ff;
   logic                   out_vld_in;
   key_vec_type            out_keys_ff;
   logic                   out_enter_ff;
   step_type               out_step_ff;
   logic                   out_free;
   logic                   fire;
   logic                   req_beat;
   key_vec_type            keys_cur;
   key_vec_type            keys_next;
   step_type               step;
   scan_ctl_type [NUM_BTN-1:0] scan_ctl;

   // configuration register writes
   always_comb begin
      debounce_in   = debounce_ff;
      long_press_in = long_press_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_DEBOUNCE:   debounce_in   = csr_wdata;
            REG_LONG_PRESS: long_press_in = csr_wdata;
            default:        debounce_in   = debounce_ff;
         endcase
      end
   end

   // handshake: the result register frees when taken, the input register
   // drains into it
   assign out_free   = !out_vld_ff || rsp_tready;
   assign fire       = in_vld_ff && out_free;
   assign req_tready = !in_vld_ff || out_free;
   assign req_beat   = req_tvalid && req_tready;
   assign in_vld_in  = req_beat || (in_vld_ff && !fire);
   assign out_vld_in = fire || (out_vld_ff && !rsp_tready);

   // per-button scan engines
   for (genvar g = 0; g < NUM_BTN; g++) begin : g_btn
      assign scan_ctl[g].scan_en = fire && (in_op_ff == OP_SCAN);
      assign scan_ctl[g].level   = in_pins_ff[g];

      bdlp_btn u_btn (
         .clock            (clock),
         .reset            (reset),
         .ctl              (scan_ctl[g]),
         .debounce_ticks   (debounce_ff),
         .long_press_ticks (long_press_ff),
         .key_cur          (keys_cur[g]),
         .key_nxt          (keys_next[g])
      );
   end

   // poll step logic
   bdlp_poll u_poll (
      .clock      (clock),
      .reset      (reset),
      .poll_en    (fire && (in_op_ff == OP_POLL)),
      .key_states (keys_cur),
      .step       (step)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff   <= DEBOUNCE_RESET;
         long_press_ff <= LONG_PRESS_RESET;
         in_vld_ff     <= 1'b0;
         out_vld_ff    <= 1'b0;
      end else begin
         debounce_ff   <= debounce_in;
         long_press_ff <= long_press_in;
         in_vld_ff     <= in_vld_in;
         out_vld_ff    <= out_vld_in;
      end
   end

   // input payload register
   always_ff @(posedge clock) begin
      if (req_beat) begin
         in_op_ff   <= req_tuser;
         in_pins_ff <= req_tdata[NUM_BTN-1:0];
      end
   end

   // result payload register
   always_ff @(posedge clock) begin
      if (fire) begin
         out_keys_ff  <= keys_next;
         out_enter_ff <= (keys_next[ENTER_BTN] != KS_RELEASED);
         out_step_ff  <= step;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {7'd0, out_step_ff, out_enter_ff, out_keys_ff};

endmodule

### rtl/bdlp_checker.sv
// port-level checks for the button debounce and long-press encoder
module bdlp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);
   import bdlp_pkg::*;

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result beat changed");

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   // enter flag follows the middle button key state
   a_enter: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[6] == (rsp_tdata[3:2] != KS_RELEASED))
      else $error("enter flag disagrees with middle key state");

   // step is -1, 0 or +1 and key states are legal codes
   a_codes: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[8:7] != 2'b10 && rsp_tdata[1:0] != 2'b11 &&
                     rsp_tdata[3:2] != 2'b11 && rsp_tdata[5:4] != 2'b11)
      else $error("illegal step or key state code");

endmodule

bind button_debounce_long_press_encoder bdlp_checker u_bdlp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

### tb/sv/button_debounce_long_press_encoder_tb.sv
// self-checking testbench for the three-button debouncer with long-press encoder
module button_debounce_long_press_encoder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bdlp_pkg::*;

   // one result beat
   typedef struct packed {
      logic [5:0] keys;
      logic       enter;
      step_type   step;
   } enc_result_type;

   // one directed beat; typed rows carry a hand-written result
   typedef struct packed {
      logic           op;
      logic [2:0]     pins;
      logic           typed;
      enc_result_type want;
   } stim_row_type;

   localparam int NUM_DIRECTED = 25;
   localparam int NUM_PHASES   = 10;
   localparam int PHASE_ITEMS  = 40;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [2:0] pin_levels
   logic        req_tuser;   // [0] opcode
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // [5:0] key_states, [6] enter_pressed, [8:7] step
   logic        csr_we;
   logic        csr_index;
   logic [CNT_W-1:0] csr_wdata;

   // predictor state, own copy of limits and per-button history
   logic [CNT_W-1:0] debounce_lim;
   logic [CNT_W-1:0] long_lim;
   logic             last_level [NUM_BTN];
   int unsigned      hold_cnt   [NUM_BTN];
   key_state_type    key_now    [NUM_BTN];
   key_state_type    key_polled [NUM_BTN];
   int unsigned      phase_cnt  [NUM_BTN];

   enc_result_type pending_results[$];

   int fail_count  = 0;
   int n_items     = 0;
   int n_polls     = 0;
   int n_steps     = 0;
   int n_long      = 0;
   int n_results   = 0;
   int send_burst  = 0;

   // directed beats: reset state, press/release of each button, enter
   stim_row_type dir_rows [NUM_DIRECTED] = '{
      '{OP_POLL, 3'b111, 1'b1, '{6'd0, 1'b0, STEP_NONE}},
      '{OP_SCAN, 3'b111, 1'b1, '{6'd0, 1'b0, STEP_NONE}},
      '{OP_SCAN, 3'b111, 1'b1, '{6'd0, 1'b0, STEP_NONE}},
      '{OP_SCAN, 3'b111, 1'b1, '{6'd0, 1'b0, STEP_NONE}},
      '{OP_SCAN, 3'b000, 1'b0, '{6'd0, 1'b0, STEP_NONE}},
      '{OP_SCAN, 3'b000, 1'b0, '{6'd0, 1'b0, STEP_NONE}},
      '{OP_SCAN, 3'b000, 1'b0, '{6'd0, 1'b0, STEP_NONE}},
      '{OP_SCAN, 3'b000, 1'b0, '{6'd0, 1'b0, STEP_NONE}},
      '{OP_POLL, 3'b111, 1'b0, '{6'd0, 1'b0, STEP_NONE}},
      '{OP_POLL, 3'b000, 1'b0, '{6'd0, 1'b0, STEP_NONE}},
      '{OP_SCAN, 3'b111, 1'b0, '{6'd0, 1'b0, STEP_NONE}},
      '{OP_SCAN, 3'b111, 1'b0, '{6'd0, 1'b0, STEP_NONE}},
      '{OP_SCAN, 3'b111, 1'b0, '{6'd0, 1'b0, STEP_NONE}},
      '{OP_SCAN, 3'b111, 1'b0, '{6'd0, 1'b0, STEP_NONE}},
      '{OP_SCAN, 3'b011, 1'b0, '{6'd0, 1'b0, STEP_NONE}},
      '{OP_SCAN, 3'b011, 1'b0, '{6'd0, 1'b0, STEP_NONE}},
      '{OP_SCAN, 3'b011, 1'b0, '{6'd0, 1'b0, STEP_NONE}},
      '{OP_SCAN, 3'b011, 1'b0, '{6'd0, 1'b0, STEP_NONE}},
      '{OP_POLL, 3'b111, 1'b0, '{6'd0, 1'b0, STEP_NONE}},
      '{OP_SCAN, 3'b101, 1'b0, '{6'd0, 1'b0, STEP_NONE}},
      '{OP_SCAN, 3'b101, 1'b0, '{6'd0, 1'b0, STEP_NONE}},
      '{OP_SCAN, 3'b101, 1'b0, '{6'd0, 1'b0, STEP_NONE}},
      '{OP_SCAN, 3'b101, 1'b0, '{6'd0, 1'b0, STEP_NONE}},
      '{OP_POLL, 3'b010, 1'b0, '{6'd0, 1'b0, STEP_NONE}},
      '{OP_SCAN, 3'b010, 1'b0, '{6'd0, 1'b0, STEP_NONE}}
   };

   // limit settings per phase, extremes included
   logic [CNT_W-1:0] phase_debounce [NUM_PHASES] = '{
      16'd0, 16'd1, 16'd3, 16'd6, 16'd9, 16'd0, 16'd65535, 16'd65535, 16'd2, 16'd2
   };
   logic [CNT_W-1:0] phase_long [NUM_PHASES] = '{
      16'd1, 16'd4, 16'd12, 16'd6, 16'd3, 16'd65535, 16'd65535, 16'd1, 16'd7, 16'd100
   };

   button_debounce_long_press_encoder DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // hard stop if the run hangs
   initial begin
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // predictor state after reset
   task automatic clear_predictor();
      debounce_lim = DEBOUNCE_RESET;
      long_lim     = LONG_PRESS_RESET;
      for (int i = 0; i < NUM_BTN; i++) begin
         last_level[i] = 1'b1;
         hold_cnt[i]   = 0;
         key_now[i]    = KS_RELEASED;
         key_polled[i] = KS_RELEASED;
         phase_cnt[i]  = 0;
      end
   endtask

   // poll check of one direction button; returns 1 when it ends the check
   function automatic logic poll_button(int btn, step_type dir, ref step_type step);
      if (key_now[btn] != key_polled[btn] && key_now[btn] == KS_SHORT) begin
         step = dir;
         return 1'b1;
      end else if (key_now[btn] == KS_LONG) begin
         phase_cnt[btn] = (phase_cnt[btn] + 1) % REPEAT_MOD;
         step = (phase_cnt[btn] == 0) ? dir : STEP_NONE;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // next encoder result for one accepted beat, updates predictor state
   function automatic enc_result_type predict_encoder(logic op, logic [2:0] pins);
      enc_result_type res;
      int unsigned    cnt;
      step_type       step;
      step = STEP_NONE;
      if (op == OP_SCAN) begin
         // hold counters and key states
         for (int i = 0; i < NUM_BTN; i++) begin
            cnt = (pins[i] == last_level[i]) ? hold_cnt[i] + 1 : 0;
            if (cnt >= 32'(long_lim)) begin
               cnt = 32'(long_lim);
               if (pins[i] == 1'b0) key_now[i] = KS_LONG;
            end else if (cnt > 32'(debounce_lim)) begin
               key_now[i] = pins[i] ? KS_RELEASED : KS_SHORT;
            end
            hold_cnt[i]   = cnt;
            last_level[i] = pins[i];
         end
      end else begin
         // up button first, down button only if up did not decide
         if (!poll_button(UP_BTN, STEP_PLUS, step))
            void'(poll_button(DOWN_BTN, STEP_MINUS, step));
         if (key_now[UP_BTN] == KS_LONG || key_now[DOWN_BTN] == KS_LONG) n_long++;
         for (int i = 0; i < NUM_BTN; i++) key_polled[i] = key_now[i];
      end
      for (int i = 0; i < NUM_BTN; i++) res.keys[2*i +: 2] = key_now[i];
      res.enter = (key_now[ENTER_BTN] != KS_RELEASED);
      res.step  = step;
      return res;
   endfunction

   // send one beat with a random gap, predict at acceptance
   task automatic send_beat(logic op, logic [2:0] pins, logic typed, enc_result_type want);
      int gap;
      enc_result_type res;
      if (send_burst > 0) begin
         gap = 0;
         send_burst--;
      end else begin
         gap = $urandom_range(0, 11);
         if ($urandom_range(0, 15) == 0) send_burst = $urandom_range(8, 30);
      end
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = op;
      req_tdata  = {5'b0, pins};
      do @(posedge clock); while (!req_tready);
      res = predict_encoder(op, pins);
      if (op == OP_POLL) n_polls++;
      if (res.step != STEP_NONE) n_steps++;
      pending_results.push_back(typed ? want : res);
      n_items++;
      @(negedge clock);
   endtask

   task automatic send_plain(logic op, logic [2:0] pins);
      send_beat(op, pins, 1'b0, '0);
   endtask

   // wait until every result is back, then let the pipeline settle
   task automatic drain();
      req_tvalid = 1'b0;
      while (pending_results.size() > 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_limit(logic idx, logic [CNT_W-1:0] value);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      if (idx == REG_DEBOUNCE) debounce_lim = value;
      else long_lim = value;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // mostly held press patterns with polls, some random noise
   task automatic run_random(int count);
      int start;
      int lim;
      int cap;
      int len;
      logic [2:0] pattern;
      start = n_items;
      lim   = 32'(long_lim);
      cap   = (lim + 4 < 40) ? lim + 4 : 40;
      while (n_items - start < count) begin
         if ($urandom_range(0, 9) < 7) begin
            pattern = 3'($urandom_range(0, 7));
            if ($urandom_range(0, 9) == 0 && lim <= 120) len = lim + $urandom_range(0, 4);
            else len = $urandom_range(1, cap);
            for (int k = 0; k < len; k++) begin
               send_plain(OP_SCAN, pattern);
               if ($urandom_range(0, 3) == 0) send_plain(OP_POLL, 3'($urandom_range(0, 7)));
            end
            // poll bursts walk the repeat phase while held
            if ($urandom_range(0, 1) == 0)
               repeat ($urandom_range(1, 7)) send_plain(OP_POLL, 3'($urandom_range(0, 7)));
         end else begin
            repeat ($urandom_range(1, 4))
               send_plain(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
         end
      end
   endtask

   // result side: random stalls, field-by-field compare against the oldest entry
   initial begin : result_sink
      int stall;
      int burst;
      enc_result_type got;
      enc_result_type want;
      burst = 0;
      rsp_tready = 1'b0;
      forever begin
         if (burst > 0) begin
            stall = 0;
            burst--;
         end else begin
            stall = $urandom_range(0, 11);
            if ($urandom_range(0, 15) == 0) burst = $urandom_range(8, 30);
         end
         if (stall > 0) begin
            rsp_tready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         got.keys  = rsp_tdata[5:0];
         got.enter = rsp_tdata[6];
         got.step  = rsp_tdata[8:7];
         n_results++;
         if (pending_results.size() == 0) begin
            if (fail_count < 10) $display("result beat %0d with nothing pending: %h",
                                          n_results, got);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            if (got.keys !== want.keys) begin
               if (fail_count < 10) $display("beat %0d key_states exp %b got %b",
                                             n_results, want.keys, got.keys);
               fail_count++;
            end
            if (got.enter !== want.enter) begin
               if (fail_count < 10) $display("beat %0d enter_pressed exp %b got %b",
                                             n_results, want.enter, got.enter);
               fail_count++;
            end
            if (got.step !== want.step) begin
               if (fail_count < 10) $display("beat %0d step exp %0d got %0d",
                                             n_results, want.step, got.step);
               fail_count++;
            end
         end
         @(negedge clock);
      end
   end

   // reset, directed rows, then random traffic under each limit setting
   initial begin : stimulus
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = OP_SCAN;
      csr_we     = 1'b0;
      csr_index  = REG_DEBOUNCE;
      csr_wdata  = '0;
      clear_predictor();
      repeat (3) @(negedge clock);
      reset = 1'b0;

      for (int r = 0; r < NUM_DIRECTED; r++)
         send_beat(dir_rows[r].op, dir_rows[r].pins, dir_rows[r].typed, dir_rows[r].want);
      run_random(30);

      for (int p = 0; p < NUM_PHASES; p++) begin
         drain();
         write_limit(REG_DEBOUNCE, phase_debounce[p]);
         write_limit(REG_LONG_PRESS, phase_long[p]);
         run_random(PHASE_ITEMS);
      end

      drain();
      repeat (8) @(negedge clock);
      $display("%0d beats (%0d polls) over %0d limit settings, %0d results", n_items,
               n_polls, NUM_PHASES + 1, n_results);
      $display("%0d nonzero steps, %0d polls with a long-held direction button",
               n_steps, n_long);
      if (fail_count == 0 && pending_results.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d mismatches, %0d results missing", fail_count,
                  pending_results.size());
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
